@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros of the voice allocator, used by mva_ctrl. Each macro expects
// i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define MVA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("voice allocator assertion failed");

// Next-cycle implication, disabled in reset
`define MVA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("voice allocator assertion failed");

`endif

@@ hdl/mva_pkg.sv @@
// ----------------------------------------------------------------------------
// mva_pkg
// Types, constants and helpers of the MIDI voice allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package mva_pkg;

    localparam int NUM_VOICES = 16;
    localparam int VOICE_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int MASK_W     = 16;
    localparam int VOICE_OUT_W = 4;
    localparam int CMD_W      = 2;
    localparam int CH_W       = 4;
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;

    localparam logic [VOICE_W-1:0] LAST_VOICE = VOICE_W'(NUM_VOICES - 1);

    typedef logic [VOICE_W-1:0]    t_voice_idx;
    typedef logic [NUM_VOICES-1:0] t_voice_vec;

    typedef enum logic [CMD_W-1:0] {
        CMD_NOTE_ON   = 2'd0,
        CMD_NOTE_OFF  = 2'd1,
        CMD_CLEAR_ALL = 2'd2,
        CMD_NONE      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CH_W-1:0]   midi_channel;
        logic [NOTE_W-1:0] note_number;
        logic [VEL_W-1:0]  velocity;
    } t_event;

    typedef struct packed {
        logic              busy;
        logic [NOTE_W-1:0] note;
        logic [CH_W-1:0]   ch;
    } t_voice_rd;

    typedef struct packed {
        logic              clr_en;
        t_voice_idx        clr_idx;
        logic              wr_en;
        t_voice_idx        wr_idx;
        logic [NOTE_W-1:0] note;
        logic [CH_W-1:0]   ch;
    } t_tbl_cmd;

    typedef struct packed {
        t_voice_idx voice;
        logic       assigned;
        logic       stolen;
        t_voice_vec released;
    } t_result;

    // Low 16 voices of a voice vector, zero padded when there are fewer
    function automatic logic [MASK_W-1:0] to_mask(input t_voice_vec v);
        logic [MASK_W+NUM_VOICES-1:0] ext;
        ext = {{MASK_W{1'b0}}, v};
        return ext[MASK_W-1:0];
    endfunction

    // Low 4 bits of a voice number
    function automatic logic [VOICE_OUT_W-1:0] to_voice_out(input t_voice_idx v);
        logic [VOICE_OUT_W+VOICE_W-1:0] ext;
        ext = {{VOICE_OUT_W{1'b0}}, v};
        return ext[VOICE_OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/mva_if.sv @@
// ----------------------------------------------------------------------------
// mva_evt_if / mva_res_if
// Valid/ready channels for note events and allocation results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mva_evt_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [3:0] midi_channel;
    logic [6:0] note_number;
    logic [6:0] velocity;

    modport source (output valid, command, midi_channel, note_number, velocity,
                    input ready);
    modport sink   (input valid, command, midi_channel, note_number, velocity,
                    output ready);
endinterface

interface mva_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  assigned_voice;
    logic        did_assign;
    logic        was_stolen;
    logic [15:0] released_mask;
    logic [15:0] gate_mask;

    modport source (output valid, assigned_voice, did_assign, was_stolen,
                    released_mask, gate_mask, input ready);
    modport sink   (input valid, assigned_voice, did_assign, was_stolen,
                    released_mask, gate_mask, output ready);
endinterface

`default_nettype wire

@@ hdl/mva_voice_table.sv @@
// ----------------------------------------------------------------------------
// mva_voice_table
// Per-voice state: busy flags (reset cleared), held note and channel.
// One read port at the scan index, one write and one release per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mva_voice_table (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  mva_pkg::t_voice_idx   i_rd_idx,
    input  mva_pkg::t_tbl_cmd     i_cmd,
    output mva_pkg::t_voice_rd    o_rd,
    output mva_pkg::t_voice_vec   o_busy
);
    import mva_pkg::*;

    t_voice_vec        r_busy;
    logic [NOTE_W-1:0] r_note [NUM_VOICES];
    logic [CH_W-1:0]   r_ch   [NUM_VOICES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else begin
            if (i_cmd.clr_en) begin
                r_busy[i_cmd.clr_idx] <= 1'b0;
            end
            if (i_cmd.wr_en) begin
                r_busy[i_cmd.wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_note[i_cmd.wr_idx] <= i_cmd.note;
            r_ch[i_cmd.wr_idx]   <= i_cmd.ch;
        end
    end

    assign o_rd.busy = r_busy[i_rd_idx];
    assign o_rd.note = r_note[i_rd_idx];
    assign o_rd.ch   = r_ch[i_rd_idx];
    assign o_busy    = r_busy;

endmodule

`default_nettype wire

@@ hdl/mva_ctrl.sv @@
// ----------------------------------------------------------------------------
// mva_ctrl
// Scan sequencer: walks the voices one per cycle through a shared match
// compare, records first match and first free voice, releases matches, or on
// clear-all every busy voice; then commits note-on target, round-robin steal.
// ----------------------------------------------------------------------------
`default_nettype none

module mva_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_evt_valid,
    input  mva_pkg::t_event       i_evt,
    output logic                  o_evt_ready,
    input  mva_pkg::t_voice_rd    i_rd,
    input  mva_pkg::t_voice_vec   i_busy,
    output mva_pkg::t_voice_idx   o_rd_idx,
    output mva_pkg::t_tbl_cmd     o_tbl,
    input  wire                   i_out_free,
    output logic                  o_res_load,
    output mva_pkg::t_result      o_res
);
    import mva_pkg::*;

    t_state            r_state, n_state;
    t_cmd              r_cmd;
    logic [CH_W-1:0]   r_ch;
    logic [NOTE_W-1:0] r_note;
    t_voice_idx        r_idx, n_idx;
    logic              r_found_match, n_found_match;
    logic              r_found_free, n_found_free;
    t_voice_idx        r_match_idx, n_match_idx;
    t_voice_idx        r_free_idx, n_free_idx;
    t_voice_vec        r_released, n_released;
    t_voice_idx        r_steal_ptr, n_steal_ptr;
    t_voice_idx        r_target, n_target;
    logic              r_assigned, n_assigned;
    logic              r_stolen, n_stolen;

    logic accept;
    logic hit;
    t_cmd evt_cmd;

    assign accept  = i_evt_valid && o_evt_ready;
    // Note-on with zero velocity is a note-off
    assign evt_cmd = (t_cmd'(i_evt.command) == CMD_NOTE_ON && i_evt.velocity == '0)
                     ? CMD_NOTE_OFF : t_cmd'(i_evt.command);
    assign hit     = i_rd.busy && i_rd.note == r_note && i_rd.ch == r_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_idx         <= '0;
            r_found_match <= 1'b0;
            r_found_free  <= 1'b0;
            r_steal_ptr   <= '0;
        end else begin
            r_state       <= n_state;
            r_idx         <= n_idx;
            r_found_match <= n_found_match;
            r_found_free  <= n_found_free;
            r_steal_ptr   <= n_steal_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= evt_cmd;
            r_ch   <= i_evt.midi_channel;
            r_note <= i_evt.note_number;
        end
        r_match_idx <= n_match_idx;
        r_free_idx  <= n_free_idx;
        r_released  <= n_released;
        r_target    <= n_target;
        r_assigned  <= n_assigned;
        r_stolen    <= n_stolen;
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_found_match = r_found_match;
        n_found_free  = r_found_free;
        n_match_idx   = r_match_idx;
        n_free_idx    = r_free_idx;
        n_released    = r_released;
        n_steal_ptr   = r_steal_ptr;
        n_target      = r_target;
        n_assigned    = r_assigned;
        n_stolen      = r_stolen;
        o_evt_ready   = 1'b0;
        o_res_load    = 1'b0;
        o_tbl         = '0;
        o_tbl.note    = r_note;
        o_tbl.ch      = r_ch;

        case (r_state)
            S_IDLE: begin
                o_evt_ready = 1'b1;
                if (i_evt_valid) begin
                    n_state       = S_SCAN;
                    n_idx         = '0;
                    n_found_match = 1'b0;
                    n_found_free  = 1'b0;
                    n_released    = '0;
                end
            end
            S_SCAN: begin
                case (r_cmd)
                    CMD_NOTE_ON: begin
                        if (hit && !r_found_match) begin
                            n_found_match = 1'b1;
                            n_match_idx   = r_idx;
                        end
                        if (!i_rd.busy && !r_found_free) begin
                            n_found_free = 1'b1;
                            n_free_idx   = r_idx;
                        end
                    end
                    CMD_NOTE_OFF: begin
                        if (hit) begin
                            o_tbl.clr_en      = 1'b1;
                            o_tbl.clr_idx     = r_idx;
                            n_released[r_idx] = 1'b1;
                        end
                    end
                    CMD_CLEAR_ALL: begin
                        if (i_rd.busy) begin
                            o_tbl.clr_en      = 1'b1;
                            o_tbl.clr_idx     = r_idx;
                            n_released[r_idx] = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (r_idx == LAST_VOICE) begin
                    n_state = S_COMMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_COMMIT: begin
                n_assigned = 1'b0;
                n_stolen   = 1'b0;
                n_target   = '0;
                if (r_cmd == CMD_NOTE_ON) begin
                    n_assigned = 1'b1;
                    if (r_found_match) begin
                        n_target = r_match_idx;
                    end else if (r_found_free) begin
                        n_target = r_free_idx;
                    end else begin
                        // Steal round robin and advance the pointer
                        n_target    = r_steal_ptr;
                        n_stolen    = 1'b1;
                        n_steal_ptr = (r_steal_ptr == LAST_VOICE) ? '0 : r_steal_ptr + 1'b1;
                    end
                    o_tbl.wr_en  = 1'b1;
                    o_tbl.wr_idx = n_target;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rd_idx       = r_idx;
    assign o_res.voice    = r_target;
    assign o_res.assigned = r_assigned;
    assign o_res.stolen   = r_stolen;
    assign o_res.released = r_released;

    `include "assert_macros.svh"

    `MVA_ASSERT_NEXT(a_accept_starts_scan, accept, r_state == S_SCAN && r_idx == '0)
    `MVA_ASSERT_NOW(a_released_cleared, r_state == S_DONE, (r_released & i_busy) == '0)
    `MVA_ASSERT_NOW(a_assigned_held, r_state == S_DONE && r_assigned, i_busy[r_target])
    `MVA_ASSERT_NOW(a_steal_only_when_full, o_tbl.wr_en && r_stolen == 1'b0 && n_stolen,
                    !r_found_match && !r_found_free)

endmodule

`default_nettype wire

@@ hdl/midi_voice_allocator_top.sv @@
// ----------------------------------------------------------------------------
// midi_voice_allocator_top
// Polyphonic voice allocator with round-robin stealing.
//
// i_evt carries note-on, note-off and clear-all events (channel, note,
// velocity); a note-on with zero velocity acts as a note-off. o_res returns
// one beat per event: assigned voice, assign and steal flags, the mask of
// voices released and the gate mask of voices held afterwards.
// Each event is handled by a scan that visits one voice per cycle through a
// single match compare, then a commit state that writes the note-on target
// and a result state that loads the output register once it is free.
// i_evt.ready is high only while no event is in progress.
// Reset (synchronous, active low) frees all voices and zeroes the steal
// pointer. A result waiting in the output register holds while o_res.ready
// is low; the next event is scanned meanwhile and waits in its result
// state until the register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_voice_allocator_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    mva_evt_if.sink      i_evt,
    mva_res_if.source    o_res
);
    import mva_pkg::*;

    t_event     evt;
    t_voice_rd  rd;
    t_voice_vec busy;
    t_voice_idx rd_idx;
    t_tbl_cmd   tbl_cmd;
    t_result    res;
    logic       evt_ready;
    logic       res_load;
    logic       out_free;

    logic                   r_out_valid;
    logic [VOICE_OUT_W-1:0] r_voice;
    logic                   r_assigned;
    logic                   r_stolen;
    logic [MASK_W-1:0]      r_released;
    logic [MASK_W-1:0]      r_gate;

    assign evt.command      = i_evt.command;
    assign evt.midi_channel = i_evt.midi_channel;
    assign evt.note_number  = i_evt.note_number;
    assign evt.velocity     = i_evt.velocity;
    assign i_evt.ready      = evt_ready;

    assign out_free = !r_out_valid || o_res.ready;

    mva_voice_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (rd_idx),
        .i_cmd    (tbl_cmd),
        .o_rd     (rd),
        .o_busy   (busy)
    );

    mva_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (i_evt.valid),
        .i_evt       (evt),
        .o_evt_ready (evt_ready),
        .i_rd        (rd),
        .i_busy      (busy),
        .o_rd_idx    (rd_idx),
        .o_tbl       (tbl_cmd),
        .i_out_free  (out_free),
        .o_res_load  (res_load),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_voice    <= to_voice_out(res.voice);
            r_assigned <= res.assigned;
            r_stolen   <= res.stolen;
            r_released <= to_mask(res.released);
            r_gate     <= to_mask(busy);
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.assigned_voice = r_voice;
    assign o_res.did_assign     = r_assigned;
    assign o_res.was_stolen     = r_stolen;
    assign o_res.released_mask  = r_released;
    assign o_res.gate_mask      = r_gate;

endmodule

`default_nettype wire

@@ tb/sv/midi_voice_allocator_top_tb.sv @@
// ----------------------------------------------------------------------------
// midi_voice_allocator_top_tb
// Drives note-on, note-off, clear-all and no-op beats into the allocator and
// checks every result beat field by field. Predictions come from a behavioral
// copy of the voice table and steal pointer. An opening list covers the corner
// cases. Random traffic then fills the voices, so that reuse, release and
// round-robin steals happen often. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_voice_allocator_top_tb;
    import mva_pkg::*;

    typedef struct packed {
        logic [3:0]  voice;
        logic        assigned;
        logic        stolen;
        logic [15:0] released;
        logic [15:0] gate;
    } t_alloc;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] ch;
        logic [6:0] note;
        logic [6:0] vel;
        logic [4:0] reps;     // note number steps by one on each repeat
        logic       fixed;    // want holds the typed-in result
        t_alloc     want;
    } t_row;

    localparam int N_OPENING = 16;
    localparam int N_RANDOM  = 550;

    localparam t_row OPENING_ROWS [N_OPENING] = '{
        '{CMD_NONE,      4'd0,  7'd0,   7'd0,   5'd1,  1'b1, '{4'd0, 1'b0, 1'b0, 16'h0, 16'h0}},
        '{CMD_NOTE_OFF,  4'd15, 7'd127, 7'd127, 5'd1,  1'b1, '{4'd0, 1'b0, 1'b0, 16'h0, 16'h0}},
        '{CMD_CLEAR_ALL, 4'd0,  7'd0,   7'd0,   5'd1,  1'b1, '{4'd0, 1'b0, 1'b0, 16'h0, 16'h0}},
        '{CMD_NOTE_ON,   4'd0,  7'd0,   7'd1,   5'd1,  1'b1, '{4'd0, 1'b1, 1'b0, 16'h0, 16'h1}},
        '{CMD_NOTE_ON,   4'd15, 7'd127, 7'd127, 5'd1,  1'b1, '{4'd1, 1'b1, 1'b0, 16'h0, 16'h3}},
        // same note and channel again: reuse voice 0
        '{CMD_NOTE_ON,   4'd0,  7'd0,   7'd64,  5'd1,  1'b1, '{4'd0, 1'b1, 1'b0, 16'h0, 16'h3}},
        // zero velocity acts as a note-off
        '{CMD_NOTE_ON,   4'd0,  7'd0,   7'd0,   5'd1,  1'b1, '{4'd0, 1'b0, 1'b0, 16'h1, 16'h2}},
        // voice 0 is free but still remembers note 0: no match
        '{CMD_NOTE_OFF,  4'd0,  7'd0,   7'd85,  5'd1,  1'b1, '{4'd0, 1'b0, 1'b0, 16'h0, 16'h2}},
        '{CMD_NOTE_ON,   4'd14, 7'd127, 7'd42,  5'd1,  1'b0, '0},
        '{CMD_NOTE_ON,   4'd3,  7'd10,  7'd100, 5'd14, 1'b0, '0},
        // every voice busy: steal twice
        '{CMD_NOTE_ON,   4'd5,  7'd60,  7'd1,   5'd2,  1'b0, '0},
        '{CMD_NOTE_ON,   4'd5,  7'd61,  7'd127, 5'd1,  1'b0, '0},
        '{CMD_NONE,      4'd7,  7'd33,  7'd99,  5'd1,  1'b0, '0},
        '{CMD_NOTE_OFF,  4'd3,  7'd10,  7'd127, 5'd1,  1'b0, '0},
        '{CMD_CLEAR_ALL, 4'd9,  7'd77,  7'd55,  5'd1,  1'b0, '0},
        '{CMD_NONE,      4'd15, 7'd127, 7'd127, 5'd1,  1'b1, '{4'd0, 1'b0, 1'b0, 16'h0, 16'h0}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    mva_evt_if evt ();
    mva_res_if res ();

    midi_voice_allocator_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt),
        .o_res   (res)
    );

    always #4 i_clk = ~i_clk;

    // Voice table as the allocator should see it
    bit          voice_held [NUM_VOICES];
    logic [6:0]  voice_note_m [NUM_VOICES];
    logic [3:0]  voice_chan_m [NUM_VOICES];
    int          steal_ptr = 0;

    t_alloc pending_allocs [$];
    int     failures = 0;
    bit     calm = 1'b0;
    bit     use_fixed = 1'b0;
    t_alloc fixed_want = '0;

    function automatic bit holds_note(input int i, input logic [3:0] ch,
                                      input logic [6:0] note);
        return voice_held[i] && voice_note_m[i] == note && voice_chan_m[i] == ch;
    endfunction

    function automatic t_alloc allocate_voice(input t_event ev);
        t_alloc r;
        t_cmd   op;
        int     target;
        r      = '0;
        target = -1;
        op     = t_cmd'(ev.command);
        if (op == CMD_NOTE_ON && ev.velocity == 0) op = CMD_NOTE_OFF;
        case (op)
            CMD_NOTE_ON: begin
                for (int i = 0; i < NUM_VOICES; i++)
                    if (target < 0 && holds_note(i, ev.midi_channel, ev.note_number))
                        target = i;
                for (int i = 0; i < NUM_VOICES; i++)
                    if (target < 0 && !voice_held[i]) target = i;
                if (target < 0) begin
                    target    = steal_ptr;
                    steal_ptr = (steal_ptr + 1) % NUM_VOICES;
                    r.stolen  = 1'b1;
                end
                voice_held[target]   = 1'b1;
                voice_note_m[target] = ev.note_number;
                voice_chan_m[target] = ev.midi_channel;
                r.voice    = 4'(target);
                r.assigned = 1'b1;
            end
            CMD_NOTE_OFF: begin
                for (int i = 0; i < NUM_VOICES; i++) begin
                    if (holds_note(i, ev.midi_channel, ev.note_number)) begin
                        voice_held[i] = 1'b0;
                        if (i < 16) r.released[i] = 1'b1;
                    end
                end
            end
            CMD_CLEAR_ALL: begin
                for (int i = 0; i < NUM_VOICES; i++) begin
                    if (i < 16) r.released[i] = voice_held[i];
                    voice_held[i] = 1'b0;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < NUM_VOICES && i < 16; i++) r.gate[i] = voice_held[i];
        return r;
    endfunction

    task automatic report_field(input string name, input logic [15:0] want_v,
                                input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            failures++;
        end
    endtask

    // Hold the beat until the allocator takes it
    task automatic drive_event(input t_event ev, input bit fixed, input t_alloc want);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 8) begin
            evt.valid <= 1'b0;
            @(negedge i_clk);
        end
        evt.valid        <= 1'b1;
        evt.command      <= ev.command;
        evt.midi_channel <= ev.midi_channel;
        evt.note_number  <= ev.note_number;
        evt.velocity     <= ev.velocity;
        use_fixed  = fixed;
        fixed_want = want;
        do @(posedge i_clk); while (!(evt.valid && evt.ready));
    endtask

    // Event and result monitor
    always @(posedge i_clk) begin
        t_event beat;
        t_alloc want;
        if (i_rst_n) begin
            if (evt.valid && evt.ready) begin
                beat.command      = evt.command;
                beat.midi_channel = evt.midi_channel;
                beat.note_number  = evt.note_number;
                beat.velocity     = evt.velocity;
                want = allocate_voice(beat);
                if (use_fixed) want = fixed_want;
                pending_allocs = {pending_allocs, want};
            end
            if (res.valid && res.ready) begin
                if (pending_allocs.size() == 0) begin
                    $error("result beat with no note event outstanding");
                    failures++;
                end else begin
                    want = pending_allocs.pop_front();
                    report_field("assigned_voice", 16'(want.voice), 16'(res.assigned_voice));
                    report_field("did_assign", 16'(want.assigned), 16'(res.did_assign));
                    report_field("was_stolen", 16'(want.stolen), 16'(res.was_stolen));
                    report_field("released_mask", want.released, res.released_mask);
                    report_field("gate_mask", want.gate, res.gate_mask);
                end
            end
        end
    end

    // Result sink with random back-pressure
    initial begin
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res.ready <= calm || ($urandom_range(99) >= 8);
        end
    end

    initial begin
        t_event ev;
        int     n;
        int     pick;
        int     busy_idx [$];
        i_rst_n          = 1'b0;
        evt.valid        = 1'b0;
        evt.command      = CMD_NONE;
        evt.midi_channel = '0;
        evt.note_number  = '0;
        evt.velocity     = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_OPENING; r++) begin
            for (int k = 0; k < OPENING_ROWS[r].reps; k++) begin
                ev.command      = OPENING_ROWS[r].command;
                ev.midi_channel = OPENING_ROWS[r].ch;
                ev.note_number  = OPENING_ROWS[r].note + 7'(k);
                ev.velocity     = OPENING_ROWS[r].vel;
                drive_event(ev, OPENING_ROWS[r].fixed, OPENING_ROWS[r].want);
            end
        end

        n = 0;
        while (n < N_RANDOM) begin
            calm = (n >= 200 && n < 330);
            pick = $urandom_range(99);
            ev.midi_channel = 4'($urandom_range(15));
            ev.note_number  = 7'($urandom_range(127));
            ev.velocity     = 7'($urandom_range(127));
            if (pick < 3) begin
                ev.command = CMD_NONE;
            end else if (pick < 6) begin
                ev.command = CMD_CLEAR_ALL;
            end else if (pick < 30) begin
                // mostly release a note that is actually held
                ev.command = CMD_NOTE_OFF;
                busy_idx.delete();
                for (int i = 0; i < NUM_VOICES; i++)
                    if (voice_held[i]) busy_idx = {busy_idx, i};
                if (busy_idx.size() != 0 && $urandom_range(3) != 0) begin
                    pick = busy_idx[$urandom_range(busy_idx.size() - 1)];
                    ev.midi_channel = voice_chan_m[pick];
                    ev.note_number  = voice_note_m[pick];
                end
            end else begin
                ev.command = CMD_NOTE_ON;
                // narrow pool so that reuse and matching note-offs are common
                if ($urandom_range(1) == 0) begin
                    ev.midi_channel = 4'($urandom_range(3));
                    ev.note_number  = 7'(56 + $urandom_range(15));
                end
                if ($urandom_range(99) < 8) ev.velocity = '0;
            end
            drive_event(ev, 1'b0, '0);
            if (ev.command != CMD_NONE) n++;
        end
        calm = 1'b0;

        @(negedge i_clk);
        evt.valid <= 1'b0;
        while (pending_allocs.size() != 0) @(posedge i_clk);
        repeat (NUM_VOICES + 8) @(posedge i_clk);
        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
